/* rtl/core/pxb_pkg.sv */
// pxb_pkg: shared constants, controller states, datapath operations and status flags
// for the prefix xor basis block; used by pxb_ctrl, pxb_dp and the top level
`timescale 1ns / 1ps

package pxb_pkg;

   // default sizing
   localparam int MAX_ITEMS_DEF  = 256;
   localparam int VALUE_BITS_DEF = 60;

   // fixed port field widths
   localparam int VALUE_W = 60;
   localparam int RANGE_W = 8;

   // controller states
   typedef enum logic [4:0] {
      S_IDLE,
      S_DISP,
      S_A_W0,
      S_A_SLEN,
      S_A_SLENW,
      S_A_SRD,
      S_A_SUSE,
      S_A_DRD,
      S_A_DUSE,
      S_A_DEC,
      S_A_CCHK,
      S_A_CRD,
      S_A_CUSE,
      S_A_WLEN,
      S_Q_LEN,
      S_Q_LENW,
      S_Q_RD,
      S_Q_USE,
      S_Q_DONE
   } state_type;

   // datapath operations, one per cycle
   typedef enum logic [4:0] {
      OP_IDLE,
      OP_LOAD,
      OP_INVALID,
      OP_RESPOND,
      OP_W0,
      OP_RD_SLEN,
      OP_CAP_SLEN,
      OP_RD_SRC,
      OP_CAP_SRC,
      OP_RD_DST,
      OP_REDUCE,
      OP_DECIDE,
      OP_COPY,
      OP_WLEN,
      OP_RD_QLEN,
      OP_RD_Q,
      OP_Q_STEP
   } op_type;

   // datapath status seen by the controller
   typedef struct packed {
      logic act_query;
      logic full;
      logic i_zero;
      logic q_oob;
      logic k_end_a;
      logic k_end_q;
      logic j_end;
      logic x_zero;
      logic q_zero;
      logic copy_more;
      logic out_free;
   } status_type;

endpackage

/* rtl/core/pxb_dp.sv */
// pxb_dp: basis memory, length memory, reduction datapath and result register
// depends on pxb_pkg (op_type, status_type)
`timescale 1ns / 1ps

module pxb_dp #(
   parameter int MAX_ITEMS  = pxb_pkg::MAX_ITEMS_DEF,
   parameter int VALUE_BITS = pxb_pkg::VALUE_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  pxb_pkg::op_type              op,
   output pxb_pkg::status_type          status,
   input  logic                         req_action,
   input  logic [pxb_pkg::VALUE_W-1:0]  req_value,
   input  logic [pxb_pkg::RANGE_W-1:0]  req_left,
   input  logic [pxb_pkg::RANGE_W-1:0]  req_right,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_representable,
   output logic                         rsp_query_valid
);

   localparam int SLOTS  = VALUE_BITS + 1;
   localparam int SLOT_W = $clog2(SLOTS);
   localparam int LEN_W  = $clog2(SLOTS + 1);
   localparam int IDX_W  = $clog2(MAX_ITEMS);
   localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
   localparam int ENT_W  = VALUE_BITS + IDX_W;
   localparam int ADDR_W = IDX_W + SLOT_W;
   localparam int DEPTH  = MAX_ITEMS * (2 ** SLOT_W);

   // storage
   logic [ENT_W-1:0] mem [DEPTH];
   logic [LEN_W-1:0] len_mem [MAX_ITEMS];
   logic [ENT_W-1:0] rd_ff;
   logic [LEN_W-1:0] len_rd_ff;

   // working registers
   logic [CNT_W-1:0]          count_ff, count_in;
   logic                      act_ff;
   logic [VALUE_BITS-1:0]     val_ff;
   logic [VALUE_BITS-1:0]     x_ff, x_in;
   logic [IDX_W-1:0]          spos_ff, spos_in;
   logic [pxb_pkg::RANGE_W-1:0] left_ff, right_ff;
   logic [LEN_W-1:0]          j_ff, j_in, k_ff, k_in, dlen_ff, dlen_in, slen_ff, slen_in;
   logic                      res_repr_ff, res_repr_in, res_qv_ff, res_qv_in;
   logic                      rsp_valid_ff, rsp_valid_in, rsp_repr_ff, rsp_qv_ff;

   logic [63:0]           value_ext;
   logic [IDX_W-1:0]      cur_idx, prev_idx, right_idx;
   logic [VALUE_BITS-1:0] rd_val, y_val, x_red;
   logic [IDX_W-1:0]      rd_pos;
   logic                  rd_en, we, len_rd_en, len_we;
   logic [ADDR_W-1:0]     rd_addr, wr_addr;
   logic [ENT_W-1:0]      wr_data;
   logic [IDX_W-1:0]      len_rd_addr;
   logic                  out_free;

   assign value_ext = 64'(req_value);
   assign cur_idx   = IDX_W'(count_ff);
   assign prev_idx  = IDX_W'(count_ff - CNT_W'(1));
   assign right_idx = IDX_W'(right_ff);
   assign rd_val    = rd_ff[ENT_W-1:IDX_W];
   assign rd_pos    = rd_ff[IDX_W-1:0];
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // one reduction step x = min(x, x ^ b)
   assign y_val = x_ff ^ rd_val;
   assign x_red = (y_val < x_ff) ? y_val : x_ff;

   // memory port control
   always_comb begin
      rd_en       = 1'b0;
      rd_addr     = {prev_idx, SLOT_W'(j_ff)};
      we          = 1'b0;
      wr_addr     = {cur_idx, SLOT_W'(dlen_ff)};
      wr_data     = {x_ff, spos_ff};
      len_rd_en   = 1'b0;
      len_rd_addr = prev_idx;
      len_we      = 1'b0;
      unique case (op)
         pxb_pkg::OP_RD_SRC: rd_en = 1'b1;
         pxb_pkg::OP_RD_DST: begin
            rd_en   = 1'b1;
            rd_addr = {cur_idx, SLOT_W'(k_ff)};
         end
         pxb_pkg::OP_RD_Q: begin
            rd_en   = 1'b1;
            rd_addr = {right_idx, SLOT_W'(k_ff)};
         end
         pxb_pkg::OP_W0: begin
            we      = 1'b1;
            wr_addr = {cur_idx, SLOT_W'(0)};
            wr_data = {val_ff, cur_idx};
         end
         pxb_pkg::OP_DECIDE: we = (x_ff != '0) && (dlen_ff < LEN_W'(SLOTS));
         pxb_pkg::OP_COPY: begin
            we      = 1'b1;
            wr_data = rd_ff;
         end
         pxb_pkg::OP_RD_SLEN: len_rd_en = 1'b1;
         pxb_pkg::OP_RD_QLEN: begin
            len_rd_en   = 1'b1;
            len_rd_addr = right_idx;
         end
         pxb_pkg::OP_WLEN: len_we = 1'b1;
         default: ;
      endcase
   end

   // memories with registered reads
   always_ff @(posedge clock) begin
      if (we) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_ff <= mem[rd_addr];
      end
      if (len_we) begin
         len_mem[cur_idx] <= dlen_ff;
      end
      if (len_rd_en) begin
         len_rd_ff <= len_mem[len_rd_addr];
      end
   end

   // next values of working registers
   always_comb begin
      count_in    = count_ff;
      x_in        = x_ff;
      spos_in     = spos_ff;
      j_in        = j_ff;
      k_in        = k_ff;
      dlen_in     = dlen_ff;
      slen_in     = slen_ff;
      res_repr_in = res_repr_ff;
      res_qv_in   = res_qv_ff;
      unique case (op)
         pxb_pkg::OP_LOAD: x_in = value_ext[VALUE_BITS-1:0];
         pxb_pkg::OP_INVALID: begin
            res_repr_in = 1'b0;
            res_qv_in   = 1'b0;
         end
         pxb_pkg::OP_W0: dlen_in = LEN_W'(1);
         pxb_pkg::OP_CAP_SLEN: begin
            slen_in = len_rd_ff;
            j_in    = '0;
            k_in    = '0;
         end
         pxb_pkg::OP_CAP_SRC: begin
            x_in    = rd_val;
            spos_in = rd_pos;
            k_in    = '0;
         end
         pxb_pkg::OP_REDUCE: begin
            x_in = x_red;
            k_in = k_ff + LEN_W'(1);
         end
         pxb_pkg::OP_DECIDE: begin
            if ((x_ff != '0) && (dlen_ff < LEN_W'(SLOTS))) begin
               dlen_in = dlen_ff + LEN_W'(1);
            end
            j_in = j_ff + LEN_W'(1);
         end
         pxb_pkg::OP_COPY: begin
            dlen_in = dlen_ff + LEN_W'(1);
            j_in    = j_ff + LEN_W'(1);
         end
         pxb_pkg::OP_WLEN: count_in = count_ff + CNT_W'(1);
         pxb_pkg::OP_Q_STEP: begin
            x_in        = x_red;
            k_in        = k_ff + LEN_W'(1);
            res_repr_in = (x_red == '0) && (32'(rd_pos) >= 32'(left_ff));
            res_qv_in   = 1'b1;
         end
         default: ;
      endcase
   end

   // output register with handshake
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (op == pxb_pkg::OP_RESPOND) begin
         rsp_valid_in = 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      x_ff        <= x_in;
      spos_ff     <= spos_in;
      j_ff        <= j_in;
      k_ff        <= k_in;
      dlen_ff     <= dlen_in;
      slen_ff     <= slen_in;
      res_repr_ff <= res_repr_in;
      res_qv_ff   <= res_qv_in;
      if (op == pxb_pkg::OP_LOAD) begin
         act_ff   <= req_action;
         val_ff   <= value_ext[VALUE_BITS-1:0];
         left_ff  <= req_left;
         right_ff <= req_right;
      end
      if (op == pxb_pkg::OP_RESPOND) begin
         rsp_repr_ff <= res_repr_ff;
         rsp_qv_ff   <= res_qv_ff;
      end
   end

   // status flags
   always_comb begin
      status.act_query = act_ff;
      status.full      = (count_ff == CNT_W'(MAX_ITEMS));
      status.i_zero    = (count_ff == '0);
      status.q_oob     = (32'(right_ff) >= 32'(count_ff));
      status.k_end_a   = ((k_ff + LEN_W'(1)) == dlen_ff);
      status.k_end_q   = ((k_ff + LEN_W'(1)) == slen_ff);
      status.j_end     = ((j_ff + LEN_W'(1)) == slen_ff);
      status.x_zero    = (x_ff == '0);
      status.q_zero    = (x_red == '0);
      status.copy_more = (j_ff < slen_ff) && (dlen_ff < LEN_W'(SLOTS));
      status.out_free  = out_free;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_representable = rsp_repr_ff;
   assign rsp_query_valid   = rsp_qv_ff;

   // copy never writes past the last slot of a prefix
   a_copy_slot: assert property (@(posedge clock) disable iff (reset)
      (op == pxb_pkg::OP_COPY) |-> (dlen_ff < LEN_W'(SLOTS)))
      else $error("copy beyond slot range");

   // a result is loaded only when the output register can take it
   a_rsp_free: assert property (@(posedge clock) disable iff (reset)
      (op == pxb_pkg::OP_RESPOND) |-> out_free)
      else $error("result overwrites pending beat");

   // the previous prefix is read only when one exists
   a_prev_exists: assert property (@(posedge clock) disable iff (reset)
      (op == pxb_pkg::OP_RD_SLEN) |-> (count_ff != '0))
      else $error("previous prefix read with empty sequence");

endmodule

/* rtl/core/pxb_ctrl.sv */
// pxb_ctrl: sequencer for append and query walks over the basis memory
// depends on pxb_pkg (state_type, op_type, status_type)
`timescale 1ns / 1ps

module pxb_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  pxb_pkg::status_type status,
   output pxb_pkg::op_type     op
);

   pxb_pkg::state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pxb_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pxb_pkg::S_IDLE:    if (req_valid) state_in = pxb_pkg::S_DISP;
         pxb_pkg::S_DISP: begin
            if (status.act_query) begin
               state_in = status.q_oob ? pxb_pkg::S_Q_DONE : pxb_pkg::S_Q_LEN;
            end else begin
               state_in = status.full ? pxb_pkg::S_IDLE : pxb_pkg::S_A_W0;
            end
         end
         pxb_pkg::S_A_W0:    state_in = status.i_zero ? pxb_pkg::S_A_WLEN : pxb_pkg::S_A_SLEN;
         pxb_pkg::S_A_SLEN:  state_in = pxb_pkg::S_A_SLENW;
         pxb_pkg::S_A_SLENW: state_in = pxb_pkg::S_A_SRD;
         pxb_pkg::S_A_SRD:   state_in = pxb_pkg::S_A_SUSE;
         pxb_pkg::S_A_SUSE:  state_in = pxb_pkg::S_A_DRD;
         pxb_pkg::S_A_DRD:   state_in = pxb_pkg::S_A_DUSE;
         pxb_pkg::S_A_DUSE:  state_in = status.k_end_a ? pxb_pkg::S_A_DEC : pxb_pkg::S_A_DRD;
         pxb_pkg::S_A_DEC: begin
            priority if (status.x_zero) state_in = pxb_pkg::S_A_CCHK;
            else if (status.j_end)      state_in = pxb_pkg::S_A_WLEN;
            else                        state_in = pxb_pkg::S_A_SRD;
         end
         pxb_pkg::S_A_CCHK:  state_in = status.copy_more ? pxb_pkg::S_A_CRD : pxb_pkg::S_A_WLEN;
         pxb_pkg::S_A_CRD:   state_in = pxb_pkg::S_A_CUSE;
         pxb_pkg::S_A_CUSE:  state_in = pxb_pkg::S_A_CCHK;
         pxb_pkg::S_A_WLEN:  state_in = pxb_pkg::S_IDLE;
         pxb_pkg::S_Q_LEN:   state_in = pxb_pkg::S_Q_LENW;
         pxb_pkg::S_Q_LENW:  state_in = pxb_pkg::S_Q_RD;
         pxb_pkg::S_Q_RD:    state_in = pxb_pkg::S_Q_USE;
         pxb_pkg::S_Q_USE: begin
            if (status.q_zero || status.k_end_q) state_in = pxb_pkg::S_Q_DONE;
            else                                 state_in = pxb_pkg::S_Q_RD;
         end
         pxb_pkg::S_Q_DONE:  if (status.out_free) state_in = pxb_pkg::S_IDLE;
         default:            state_in = pxb_pkg::S_IDLE;
      endcase
   end

   // datapath operation per state
   always_comb begin
      op        = pxb_pkg::OP_IDLE;
      req_stall = (state_ff != pxb_pkg::S_IDLE);
      unique case (state_ff)
         pxb_pkg::S_IDLE:    if (req_valid) op = pxb_pkg::OP_LOAD;
         pxb_pkg::S_DISP:    if (status.act_query && status.q_oob) op = pxb_pkg::OP_INVALID;
         pxb_pkg::S_A_W0:    op = pxb_pkg::OP_W0;
         pxb_pkg::S_A_SLEN:  op = pxb_pkg::OP_RD_SLEN;
         pxb_pkg::S_A_SLENW: op = pxb_pkg::OP_CAP_SLEN;
         pxb_pkg::S_A_SRD:   op = pxb_pkg::OP_RD_SRC;
         pxb_pkg::S_A_SUSE:  op = pxb_pkg::OP_CAP_SRC;
         pxb_pkg::S_A_DRD:   op = pxb_pkg::OP_RD_DST;
         pxb_pkg::S_A_DUSE:  op = pxb_pkg::OP_REDUCE;
         pxb_pkg::S_A_DEC:   op = pxb_pkg::OP_DECIDE;
         pxb_pkg::S_A_CCHK:  op = pxb_pkg::OP_IDLE;
         pxb_pkg::S_A_CRD:   op = pxb_pkg::OP_RD_SRC;
         pxb_pkg::S_A_CUSE:  op = pxb_pkg::OP_COPY;
         pxb_pkg::S_A_WLEN:  op = pxb_pkg::OP_WLEN;
         pxb_pkg::S_Q_LEN:   op = pxb_pkg::OP_RD_QLEN;
         pxb_pkg::S_Q_LENW:  op = pxb_pkg::OP_CAP_SLEN;
         pxb_pkg::S_Q_RD:    op = pxb_pkg::OP_RD_Q;
         pxb_pkg::S_Q_USE:   op = pxb_pkg::OP_Q_STEP;
         pxb_pkg::S_Q_DONE:  if (status.out_free) op = pxb_pkg::OP_RESPOND;
         default:            op = pxb_pkg::OP_IDLE;
      endcase
   end

endmodule

/* rtl/core/prefix_xor_basis_range_query.sv */
// Prefix xor basis with range queries. One beat is taken at a time: the block stalls its
// request side from acceptance until the beat is finished, while a query answer waiting in
// the output register does not hold up the next request. Every memory access is split
// into an address state and a registered-data state. A query reads the length of prefix
// right and walks its entries up to the one where the value reaches zero (at most
// VALUE_BITS+1), then waits for the output to drain; an out-of-range query skips the walk.
// The first append writes its value as the sole entry; a later one reduces each old entry
// against the current new list and keeps it if nonzero and room remains, and once one
// reduces to zero it copies the remaining old entries unchanged. A full append is dropped.
// The stores need no clearing pass after reset.
`timescale 1ns / 1ps

module prefix_xor_basis_range_query #(
   parameter int MAX_ITEMS  = pxb_pkg::MAX_ITEMS_DEF,
   parameter int VALUE_BITS = pxb_pkg::VALUE_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_action,
   input  logic [pxb_pkg::VALUE_W-1:0] req_value,
   input  logic [pxb_pkg::RANGE_W-1:0] req_left,
   input  logic [pxb_pkg::RANGE_W-1:0] req_right,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_representable,
   output logic                        rsp_query_valid
);

   pxb_pkg::op_type     op;
   pxb_pkg::status_type status;

   // sequencer
   pxb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .op        (op)
   );

   // storage and reduction
   pxb_dp #(
      .MAX_ITEMS  (MAX_ITEMS),
      .VALUE_BITS (VALUE_BITS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .op                (op),
      .status            (status),
      .req_action        (req_action),
      .req_value         (req_value),
      .req_left          (req_left),
      .req_right         (req_right),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_representable (rsp_representable),
      .rsp_query_valid   (rsp_query_valid)
   );

endmodule
